// ===== rtl/core/rrq_pkg.sv =====
// Package for the round-robin run queue scheduler.
// Holds the command codes, the sequencer states and the id width constants.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package rrq_pkg;

  // Process ids travel as four-bit fields, so at most sixteen can be named.
  localparam int ID_W          = 4;
  localparam int NUM_IDS       = 16;
  localparam int NUM_PROCS_DEF = 16;

  // Commands carried by one input beat.
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_SLEEP = 2'd1,
    CMD_WAKE  = 2'd2,
    CMD_ENQ   = 2'd3
  } cmd_t;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WR2
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/rrq_if.sv =====
// Valid/ready channel interfaces for the run queue scheduler.
// Depends on rrq_pkg for the id width.
`default_nettype none

// Command channel: one beat carries a command and a process id.
interface rrq_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                command;
  logic [rrq_pkg::ID_W-1:0]  process_id;

  modport source (output valid, output command, output process_id, input ready);
  modport sink   (input valid, input command, input process_id, output ready);
endinterface

// Result channel: one beat per command.
interface rrq_out_if;
  logic                      valid;
  logic                      ready;
  logic [rrq_pkg::ID_W-1:0]  current_id;
  logic                      has_current;
  logic                      switched;
  logic                      wake_accepted;
  logic                      halted;
  logic                      error;

  modport source (output valid, output current_id, output has_current, output switched,
                  output wake_accepted, output halted, output error, input ready);
  modport sink   (input valid, input current_id, input has_current, input switched,
                  input wake_accepted, input halted, input error, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/round_robin_run_queue.sv =====
// Round-robin run queue scheduler: top level with the decision logic.
// Depends on rrq_pkg, the channel interfaces in rrq_if and the ring in rrq_ring.
//
// Usage: each beat on in_chan carries a command (tick, sleep current, wake
// process_id, enqueue process_id). Every command gives exactly one beat on
// out_chan with the current process, whether one exists, whether it changed,
// whether a wake was taken, the halt flag and an error flag.
// Sequencing: a command is taken in the idle state and decided in the exec
// state, which waits while the output register holds an unaccepted result. A
// wake that resumes a halted scheduler and also requeues the current process
// writes the ring twice, the second write in a state of its own. The sequence
// is set by the single write port of the ring memory and by its registered
// read port (the queue head is read while the command is being taken).
// The result sits in an output register; the next command is taken while it
// waits. If the receiver stalls, the decision of that next command waits until
// the output register is free, and no further command is taken meanwhile.
// Reset (synchronous, active low) empties the queue, marks every process
// sleeping and clears the current process and the halt flag. The ring contents
// need no clearing, so the block is ready as soon as reset is released.
`default_nettype none

module round_robin_run_queue #(
  parameter int NUM_PROCS = rrq_pkg::NUM_PROCS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rrq_in_if.sink     in_chan,
  rrq_out_if.source  out_chan
);

  localparam int IDX_W = $clog2(NUM_PROCS);
  localparam int CNT_W = $clog2(NUM_PROCS + 1);
  localparam int ID_W  = rrq_pkg::ID_W;

  // Sequencer and command registers.
  rrq_pkg::state_t state_r, state_nxt;
  rrq_pkg::cmd_t   cmd_r;
  logic [ID_W-1:0] pid_r;

  // Scheduler state.
  logic [IDX_W-1:0]           head_r, head_nxt;
  logic [IDX_W-1:0]           tail_r, tail_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [rrq_pkg::NUM_IDS-1:0] running_r, running_nxt;
  logic [ID_W-1:0]            cur_r, cur_nxt;
  logic                       curv_r, curv_nxt;
  logic                       halt_r, halt_nxt;

  // Pending second ring write.
  logic [IDX_W-1:0] wr2_addr_r;
  logic [ID_W-1:0]  wr2_data_r;

  // Output register.
  logic            out_valid_r;
  logic [ID_W-1:0] out_cur_r;
  logic            out_has_r, out_sw_r, out_acc_r, out_halt_r, out_err_r;

  // Decision results.
  logic             sw_v, acc_v, err_v, tick_v;
  logic             wr1_en, wr2_en;
  logic [IDX_W-1:0] wr1_addr, wr2_addr;
  logic [ID_W-1:0]  wr1_data, wr2_data;
  logic [ID_W-1:0]  next_id;
  logic             pid_ok, full;

  // Handshake and ring port signals.
  logic             in_fire, exec_fire, out_free;
  logic             ring_wr_en;
  logic [IDX_W-1:0] ring_wr_addr;
  logic [ID_W-1:0]  ring_wr_data;
  logic [ID_W-1:0]  ring_rd_data;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(NUM_PROCS - 1)) ? '0 : i + IDX_W'(1);
  endfunction

  // Queue storage; the head entry is read continuously.
  rrq_ring #(.DEPTH(NUM_PROCS)) u_ring (
    .clk     (clk),
    .wr_en   (ring_wr_en),
    .wr_addr (ring_wr_addr),
    .wr_data (ring_wr_data),
    .rd_addr (head_r),
    .rd_data (ring_rd_data)
  );

  assign pid_ok = (32'(pid_r) < NUM_PROCS);
  assign full   = (count_r == CNT_W'(NUM_PROCS));

  // Decision for the command held in cmd_r.
  always_comb begin
    count_nxt   = count_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    running_nxt = running_r;
    cur_nxt     = cur_r;
    curv_nxt    = curv_r;
    halt_nxt    = halt_r;
    sw_v        = 1'b0;
    acc_v       = 1'b0;
    err_v       = 1'b0;
    tick_v      = 1'b0;
    wr1_en      = 1'b0;
    wr1_addr    = tail_r;
    wr1_data    = pid_r;
    wr2_en      = 1'b0;
    wr2_addr    = tail_r;
    wr2_data    = cur_r;
    // An empty queue that gets a pop has just taken the woken id.
    next_id     = (count_r == '0) ? pid_r : ring_rd_data;

    case (cmd_r)
      rrq_pkg::CMD_TICK: begin
        tick_v = 1'b1;
      end
      rrq_pkg::CMD_SLEEP: begin
        if (!curv_r || !running_r[cur_r]) begin
          err_v = 1'b1;
        end else begin
          running_nxt[cur_r] = 1'b0;
          tick_v = 1'b1;
        end
      end
      rrq_pkg::CMD_WAKE: begin
        if (!pid_ok) begin
          err_v = 1'b1;
        end else if (!running_r[pid_r]) begin
          if (full) begin
            err_v = 1'b1;
          end else begin
            wr1_en = 1'b1;
            tail_nxt = ring_next(tail_r);
            count_nxt = count_r + CNT_W'(1);
            running_nxt[pid_r] = 1'b1;
            acc_v = 1'b1;
            if (curv_r && halt_r) begin
              halt_nxt = 1'b0;
              tick_v = 1'b1;
            end
          end
        end
      end
      rrq_pkg::CMD_ENQ: begin
        if (!pid_ok || full) begin
          err_v = 1'b1;
        end else begin
          wr1_en = 1'b1;
          tail_nxt = ring_next(tail_r);
          count_nxt = count_r + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase

    // One scheduling decision on the state left by the command.
    if (tick_v) begin
      if (!curv_nxt) begin
        if (count_nxt == '0) begin
          err_v = 1'b1;
        end else begin
          head_nxt  = ring_next(head_r);
          count_nxt = count_nxt - CNT_W'(1);
          cur_nxt   = next_id;
          curv_nxt  = 1'b1;
          sw_v      = 1'b1;
        end
      end else if (halt_nxt) begin
        // Halted: nothing moves until a wake.
      end else if (count_nxt == '0) begin
        if (!running_nxt[cur_r]) begin
          halt_nxt = 1'b1;
        end
      end else begin
        head_nxt  = ring_next(head_r);
        count_nxt = count_nxt - CNT_W'(1);
        if (next_id != cur_r) begin
          // A running current goes back to the end of the queue.
          if (running_nxt[cur_r]) begin
            if (wr1_en) begin
              wr2_en   = 1'b1;
              wr2_addr = tail_nxt;
              wr2_data = cur_r;
            end else begin
              wr1_en   = 1'b1;
              wr1_addr = tail_nxt;
              wr1_data = cur_r;
            end
            tail_nxt  = ring_next(tail_nxt);
            count_nxt = count_nxt + CNT_W'(1);
          end
          cur_nxt = next_id;
          sw_v    = 1'b1;
        end
      end
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rrq_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = rrq_pkg::ST_EXEC;
        end
      end
      rrq_pkg::ST_EXEC: begin
        if (exec_fire) begin
          state_nxt = wr2_en ? rrq_pkg::ST_WR2 : rrq_pkg::ST_IDLE;
        end
      end
      rrq_pkg::ST_WR2: begin
        state_nxt = rrq_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = rrq_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs: handshakes and the ring write port.
  // No command beat is taken while reset is held.
  always_comb begin
    out_free       = !out_valid_r || out_chan.ready;
    in_chan.ready  = rst_n && (state_r == rrq_pkg::ST_IDLE);
    in_fire        = in_chan.valid && in_chan.ready;
    exec_fire      = (state_r == rrq_pkg::ST_EXEC) && out_free;
    ring_wr_en     = 1'b0;
    ring_wr_addr   = wr1_addr;
    ring_wr_data   = wr1_data;
    case (state_r)
      rrq_pkg::ST_EXEC: begin
        ring_wr_en = exec_fire && wr1_en;
      end
      rrq_pkg::ST_WR2: begin
        ring_wr_en   = 1'b1;
        ring_wr_addr = wr2_addr_r;
        ring_wr_data = wr2_data_r;
      end
      default: begin
      end
    endcase
  end

  // Control and scheduler state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= rrq_pkg::ST_IDLE;
      head_r    <= '0;
      tail_r    <= '0;
      count_r   <= '0;
      running_r <= '0;
      cur_r     <= '0;
      curv_r    <= 1'b0;
      halt_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (exec_fire) begin
        head_r    <= head_nxt;
        tail_r    <= tail_nxt;
        count_r   <= count_nxt;
        running_r <= running_nxt;
        cur_r     <= cur_nxt;
        curv_r    <= curv_nxt;
        halt_r    <= halt_nxt;
      end
    end
  end

  // Captured command beat and pending second write.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= rrq_pkg::cmd_t'(in_chan.command);
      pid_r <= in_chan.process_id;
    end
    if (exec_fire) begin
      wr2_addr_r <= wr2_addr;
      wr2_data_r <= wr2_data;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_cur_r  <= curv_nxt ? cur_nxt : '0;
      out_has_r  <= curv_nxt;
      out_sw_r   <= sw_v;
      out_acc_r  <= acc_v;
      out_halt_r <= halt_nxt;
      out_err_r  <= err_v;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.current_id    = out_cur_r;
  assign out_chan.has_current   = out_has_r;
  assign out_chan.switched      = out_sw_r;
  assign out_chan.wake_accepted = out_acc_r;
  assign out_chan.halted        = out_halt_r;
  assign out_chan.error         = out_err_r;

  // The fill count never passes the ring depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(NUM_PROCS))
    else $error("run queue count beyond depth");

  // An empty queue has head and tail together.
  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (head_r == tail_r))
    else $error("empty queue with head and tail apart");

  // Halting needs a current process, and that process is sleeping.
  a_halt_cur: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |-> (curv_r && !running_r[cur_r]))
    else $error("halted without a sleeping current process");

  // The second ring write only follows a decision.
  a_wr2_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rrq_pkg::ST_WR2) |-> ($past(state_r) == rrq_pkg::ST_EXEC))
    else $error("second write without a decision");

  // A decision always leaves a result beat waiting.
  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire |=> out_valid_r)
    else $error("decision without a result beat");

endmodule

`default_nettype wire

// ===== rtl/core/rrq_ring.sv =====
// Ring storage of queued process ids: one write port, one registered read port.
// Depends on rrq_pkg for the id width.
`default_nettype none

module rrq_ring #(
  parameter int DEPTH = rrq_pkg::NUM_PROCS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]      wr_addr,
  input  wire logic [rrq_pkg::ID_W-1:0]      wr_data,
  input  wire logic [$clog2(DEPTH)-1:0]      rd_addr,
  output logic      [rrq_pkg::ID_W-1:0]      rd_data
);

  logic [rrq_pkg::ID_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire
